/* hdl/bcdc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcdc_pkg: shared types, constants and functions of the base64 codec
// Holds the work-entry format passed from front to back, the configuration
// bundle, register indexes and the sextet/character mapping.
// ----------------------------------------------------------------------------
package bcdc_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] PAD_CHAR     = 8'h3D;  // '='
   localparam logic [7:0] CHAR62_RESET = 8'h2B;  // '+'
   localparam logic [7:0] CHAR63_RESET = 8'h2F;  // '/'
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHABET_62    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHABET_63    = 2'd2;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] char62;
      logic [7:0] char63;
   } cfg_type;

   // One classified group: everything the back end needs to emit its results.
   typedef struct packed {
      logic        enc;     // 1: emit characters, 0: emit bytes
      logic [2:0]  nvalid;  // characters that are not padding (encode)
      logic [2:0]  total;   // results in this group, 1..4
      logic        last;
      logic        err;
      logic [23:0] word;
   } entry_type;

   function automatic logic [7:0] sextet_to_char(input logic [5:0] v,
                                                 input logic [7:0] c62,
                                                 input logic [7:0] c63);
      logic [7:0] r;
      if (v < 6'd26) begin
         r = CHAR_UPPER_A + {2'b00, v};
      end else if (v < 6'd52) begin
         r = CHAR_LOWER_A + {2'b00, v - 6'd26};
      end else if (v < 6'd62) begin
         r = CHAR_ZERO + {2'b00, v - 6'd52};
      end else if (v == 6'd62) begin
         r = c62;
      end else begin
         r = c63;
      end
      return r;
   endfunction

   function automatic logic [5:0] char_to_sextet(input logic [7:0] c,
                                                 input logic [7:0] c62,
                                                 input logic [7:0] c63);
      logic [7:0] d;
      logic [5:0] r;
      d = 8'd0;
      if (c == c63) begin
         r = 6'd63;
      end else if (c == c62) begin
         r = 6'd62;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d = c - CHAR_UPPER_A;
         r = d[5:0];
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d = c - CHAR_LOWER_A;
         r = d[5:0] + 6'd26;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = c - CHAR_ZERO;
         r = d[5:0] + 6'd52;
      end else begin
         r = 6'd0;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* hdl/base64_codec.sv */
// Path: a result reaches the rsp_ ports through the queue slot, the back
// end's current-entry register and its output register.
// Throughput: one input transaction per cycle while req_full is low;
// results leave one per cycle while the consumer keeps popping.
// Reset: synchronous; clears group state, queue and output, restores mode
// to encode and the alphabet characters to '+' and '/'. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64_codec: streaming base64 encoder/decoder
// Front end classifies input into groups, a short queue decouples it from
// the back end, which emits characters or bytes one per cycle while popped.
// ----------------------------------------------------------------------------
module base64_codec #(
   parameter int QUEUE_DEPTH = bcdc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire  [7:0]                        req_data_in,
   input  wire                               req_last_in,
   input  wire                               req_push,
   output logic                              req_full,
   output logic [7:0]                        rsp_data_out,
   output logic                              rsp_last_out,
   output logic                              rsp_error_flag,
   output logic                              rsp_empty,
   input  wire                               rsp_pop,
   input  wire                               csr_wr_en,
   input  wire  [bcdc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [7:0]                        csr_wdata
);
   import bcdc_pkg::*;

   logic       mode_ff, mode_in;
   logic [7:0] char62_ff, char62_in;
   logic [7:0] char63_ff, char63_in;
   logic       group_clear;
   cfg_type    cfg;

   logic       q_push, q_pop, q_full, head_valid;
   entry_type  q_entry, head_entry;

   always_comb begin
      mode_in     = mode_ff;
      char62_in   = char62_ff;
      char63_in   = char63_ff;
      group_clear = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DIRECTION_MODE: begin
               mode_in     = csr_wdata[0];
               group_clear = 1'b1;
            end
            CSR_ALPHABET_62: char62_in = csr_wdata;
            CSR_ALPHABET_63: char63_in = csr_wdata;
            default:         ;
         endcase
      end
      cfg.mode   = mode_ff;
      cfg.char62 = char62_ff;
      cfg.char63 = char63_ff;
      req_full   = q_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_ENCODE;
         char62_ff <= CHAR62_RESET;
         char63_ff <= CHAR63_RESET;
      end else begin
         mode_ff   <= mode_in;
         char62_ff <= char62_in;
         char63_ff <= char63_in;
      end
   end

   bcdc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .group_clear (group_clear),
      .req_data_in (req_data_in),
      .req_last_in (req_last_in),
      .req_push    (req_push),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   bcdc_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_entry (head_entry),
      .head_valid (head_valid)
   );

   bcdc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .head_entry     (head_entry),
      .head_valid     (head_valid),
      .q_pop          (q_pop),
      .rsp_data_out   (rsp_data_out),
      .rsp_last_out   (rsp_last_out),
      .rsp_error_flag (rsp_error_flag),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop)
   );

endmodule
`default_nettype wire

/* hdl/bcdc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcdc_front: input side of the base64 codec
// Accepts one item per cycle unless the queue is full, adds it to the current
// group and, at group completion or stream end, pushes at most one entry.
// ----------------------------------------------------------------------------
module bcdc_front (
   input  wire                  clock,
   input  wire                  reset,
   input  bcdc_pkg::cfg_type    cfg,
   input  wire                  group_clear,
   input  wire  [7:0]           req_data_in,
   input  wire                  req_last_in,
   input  wire                  req_push,
   input  wire                  q_full,
   output logic                 q_push,
   output bcdc_pkg::entry_type  q_entry
);
   import bcdc_pkg::*;

   logic [17:0] held_ff, held_in;
   logic [1:0]  pos_ff, pos_in;
   logic [1:0]  pad_ff, pad_in;

   logic        accept;
   logic        is_pad;
   logic [5:0]  sextet;
   logic [2:0]  pad_total;

   always_comb begin
      accept    = req_push && !q_full;
      is_pad    = (req_data_in == PAD_CHAR);
      sextet    = is_pad ? 6'd0 : char_to_sextet(req_data_in, cfg.char62, cfg.char63);
      pad_total = {1'b0, pad_ff} + {2'b00, is_pad};

      held_in = held_ff;
      pos_in  = pos_ff;
      pad_in  = pad_ff;
      q_push  = 1'b0;
      q_entry = '0;

      if (accept) begin
         if (cfg.mode == MODE_ENCODE) begin
            q_entry.enc   = 1'b1;
            q_entry.total = 3'd4;
            q_entry.last  = req_last_in;
            if (pos_ff == 2'd2) begin
               q_entry.word   = {held_ff[15:0], req_data_in};
               q_entry.nvalid = 3'd4;
               q_push         = 1'b1;
            end else if (!req_last_in) begin
               held_in = {2'b00, held_ff[7:0], req_data_in};
               pos_in  = pos_ff + 2'd1;
            end else if (pos_ff == 2'd1) begin
               q_entry.word   = {held_ff[7:0], req_data_in, 8'h00};
               q_entry.nvalid = 3'd3;
               q_push         = 1'b1;
            end else begin
               q_entry.word   = {req_data_in, 16'h0000};
               q_entry.nvalid = 3'd2;
               q_push         = 1'b1;
            end
         end else begin
            if (pos_ff != 2'd3) begin
               if (req_last_in) begin
                  // short stream: drop the partial group, report it
                  q_entry.total = 3'd1;
                  q_entry.last  = 1'b1;
                  q_entry.err   = 1'b1;
                  q_push        = 1'b1;
               end else begin
                  held_in = {held_ff[11:0], sextet};
                  pos_in  = pos_ff + 2'd1;
                  pad_in  = pad_ff + {1'b0, is_pad};
               end
            end else begin
               q_entry.word = {held_ff, sextet};
               q_entry.last = req_last_in;
               if (pad_total < 3'd3) begin
                  q_entry.total = 3'd3 - pad_total;
                  q_push        = 1'b1;
               end else if (req_last_in) begin
                  q_entry.word  = '0;
                  q_entry.total = 3'd1;
                  q_entry.err   = 1'b1;
                  q_push        = 1'b1;
               end
            end
         end
         // any emitted group, completed decode group or end of stream closes the group
         if (q_push || (pos_ff == 2'd3 && cfg.mode == MODE_DECODE) || req_last_in) begin
            held_in = '0;
            pos_in  = '0;
            pad_in  = '0;
         end
      end

      if (group_clear) begin
         held_in = '0;
         pos_in  = '0;
         pad_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         pos_ff  <= '0;
         pad_ff  <= '0;
      end else begin
         held_ff <= held_in;
         pos_ff  <= pos_in;
         pad_ff  <= pad_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/bcdc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcdc_queue: work-entry queue between front and back
// Small circular buffer of classified groups; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module bcdc_queue #(
   parameter int QUEUE_DEPTH = bcdc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  bcdc_pkg::entry_type  push_entry,
   output logic                 full,
   input  wire                  pop,
   output bcdc_pkg::entry_type  head_entry,
   output logic                 head_valid
);
   import bcdc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full       = (count_ff == CNT_FULL);
      head_valid = (count_ff != '0);
      head_entry = slot_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/bcdc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcdc_back: output side of the base64 codec
// Takes work entries from the queue and emits their results one per cycle
// through an output register, stalling while the consumer does not pop it.
// ----------------------------------------------------------------------------
module bcdc_back (
   input  wire                  clock,
   input  wire                  reset,
   input  bcdc_pkg::cfg_type    cfg,
   input  bcdc_pkg::entry_type  head_entry,
   input  wire                  head_valid,
   output logic                 q_pop,
   output logic [7:0]           rsp_data_out,
   output logic                 rsp_last_out,
   output logic                 rsp_error_flag,
   output logic                 rsp_empty,
   input  wire                  rsp_pop
);
   import bcdc_pkg::*;

   entry_type  cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       err_ff, err_in;

   logic       final_result;
   logic       out_load;
   logic [5:0] sextet;
   logic [7:0] byte_sel;

   always_comb begin
      final_result = ({1'b0, idx_ff} == cur_ff.total - 3'd1);
      out_load     = cur_valid_ff && (!out_valid_ff || rsp_pop);
      q_pop        = head_valid && (!cur_valid_ff || (out_load && final_result));

      case (idx_ff)
         2'd0:    sextet = cur_ff.word[23:18];
         2'd1:    sextet = cur_ff.word[17:12];
         2'd2:    sextet = cur_ff.word[11:6];
         2'd3:    sextet = cur_ff.word[5:0];
         default: sextet = 6'd0;
      endcase
      case (idx_ff)
         2'd0:    byte_sel = cur_ff.word[23:16];
         2'd1:    byte_sel = cur_ff.word[15:8];
         2'd2:    byte_sel = cur_ff.word[7:0];
         default: byte_sel = 8'd0;
      endcase

      if (cur_ff.err) begin
         data_in = 8'd0;
      end else if (cur_ff.enc) begin
         data_in = ({1'b0, idx_ff} < cur_ff.nvalid) ?
                   sextet_to_char(sextet, cfg.char62, cfg.char63) : PAD_CHAR;
      end else begin
         data_in = byte_sel;
      end
      last_in = cur_ff.last && final_result;
      err_in  = cur_ff.err;

      // advance through the current entry, refill from the queue at its end or when none is held
      cur_in       = q_pop ? head_entry : cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         idx_in       = 2'd0;
      end else if (out_load) begin
         if (final_result) begin
            cur_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      rsp_data_out   = data_ff;
      rsp_last_out   = last_ff;
      rsp_error_flag = err_ff;
      rsp_empty      = !out_valid_ff;
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (out_load) begin
         data_ff <= data_in;
         last_ff <= last_in;
         err_ff  <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
`default_nettype wire

/* sim/base64_codec_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_codec_tb: self-checking bench for the streaming base64 codec
// Drives byte and character streams in both directions under several
// alphabet settings. A scoreboard class mirrors the group state and
// compares every popped result with its own prediction. Both queue sides
// stall in random bursts until the closing stretch, which runs at full rate.
// ----------------------------------------------------------------------------
import bcdc_pkg::*;

localparam int MAX_REPORTS = 10;

typedef struct packed {
   logic [7:0] data;
   logic       last;
   logic       err;
} b64_sym_type;

class b64_tracker;
   logic        mode;
   logic [7:0]  char62;
   logic [7:0]  char63;
   logic [17:0] held;
   logic [1:0]  group_pos;
   logic [1:0]  pad_seen;
   b64_sym_type pending[$];
   int          mismatches;

   function new();
      mode = MODE_ENCODE;
      char62 = CHAR62_RESET;
      char63 = CHAR63_RESET;
      mismatches = 0;
      clear_group();
   endfunction

   function void clear_group();
      held = '0;
      group_pos = '0;
      pad_seen = '0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
         CSR_DIRECTION_MODE: begin
            mode = val[0];
            clear_group();
         end
         CSR_ALPHABET_62: char62 = val;
         CSR_ALPHABET_63: char63 = val;
         default: ;
      endcase
   endfunction

   function logic [7:0] to_char(logic [5:0] v);
      if (v == 6'd63) return char63;
      if (v == 6'd62) return char62;
      if (v >= 6'd52) return CHAR_ZERO + (8'(v) - 8'd52);
      if (v >= 6'd26) return CHAR_LOWER_A + (8'(v) - 8'd26);
      return CHAR_UPPER_A + 8'(v);
   endfunction

   // register characters take priority over the fixed alphabet, 63 first
   function logic [5:0] to_sextet(logic [7:0] c);
      if (c == char63) return 6'd63;
      if (c == char62) return 6'd62;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return 6'(c - CHAR_UPPER_A);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return 6'(c - CHAR_LOWER_A + 8'd26);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return 6'(c - CHAR_ZERO + 8'd52);
      return 6'd0;
   endfunction

   function void add_sym(logic [7:0] d, logic l, logic e);
      b64_sym_type s;
      s.data = d;
      s.last = l;
      s.err = e;
      pending.push_back(s);
   endfunction

   function void encode_item(logic [7:0] d, logic l);
      logic [23:0] w;
      int          nchars;
      if (group_pos == 2'd2) begin
         w = {held[15:0], d};
         nchars = 4;
      end else if (!l) begin
         held = {2'b00, held[7:0], d};
         group_pos = group_pos + 2'd1;
         return;
      end else if (group_pos == 2'd1) begin
         w = {held[7:0], d, 8'h00};
         nchars = 3;
      end else begin
         w = {d, 16'h0000};
         nchars = 2;
      end
      for (int k = 0; k < 4; k++) begin
         add_sym((k < nchars) ? to_char(w[23-6*k -: 6]) : PAD_CHAR, l && (k == 3), 1'b0);
      end
      clear_group();
   endfunction

   function void decode_item(logic [7:0] d, logic l);
      logic        is_pad;
      logic [5:0]  v;
      logic [23:0] w;
      int          total;
      int          nbytes;
      is_pad = (d == PAD_CHAR);
      v = is_pad ? 6'd0 : to_sextet(d);
      if (group_pos != 2'd3) begin
         // a stream ending inside a group drops it and flags an error
         if (l) begin
            add_sym(8'h00, 1'b1, 1'b1);
            clear_group();
            return;
         end
         held = {held[11:0], v};
         if (is_pad) pad_seen = pad_seen + 2'd1;
         group_pos = group_pos + 2'd1;
         return;
      end
      w = {held, v};
      total = int'(pad_seen) + int'(is_pad);
      nbytes = (total >= 3) ? 0 : 3 - total;
      clear_group();
      if (nbytes == 0) begin
         if (l) add_sym(8'h00, 1'b1, 1'b1);
         return;
      end
      for (int k = 0; k < nbytes; k++) begin
         add_sym(w[23-8*k -: 8], l && (k == nbytes - 1), 1'b0);
      end
   endfunction

   function void note_item(logic [7:0] d, logic l);
      if (mode == MODE_ENCODE) encode_item(d, l);
      else decode_item(d, l);
   endfunction

   function void check_symbol(logic [7:0] d, logic l, logic e);
      b64_sym_type want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("unexpected result: data %02h last %0b err %0b", d, l, e);
         return;
      end
      want = pending.pop_front();
      if (d !== want.data || l !== want.last || e !== want.err) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("result mismatch: expected data %02h last %0b err %0b, got %02h %0b %0b",
                     want.data, want.last, want.err, d, l, e);
      end
   endfunction
endclass

module base64_codec_tb;

   localparam int                         RANDOM_ITEMS  = 75;
   localparam int                         SETTLE_CYCLES = 8;
   localparam int                         TAIL_CYCLES   = 16;
   localparam int                         STALL_LIMIT   = 400;
   localparam logic [CSR_INDEX_W-1:0]     CSR_UNUSED    = 2'd3;

   logic                   clock;
   logic                   reset;
   logic [7:0]             req_data_in;
   logic                   req_last_in;
   logic                   req_push;
   logic                   req_full;
   logic [7:0]             rsp_data_out;
   logic                   rsp_last_out;
   logic                   rsp_error_flag;
   logic                   rsp_empty;
   logic                   rsp_pop;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0]             csr_wdata;

   b64_tracker sb;
   bit         idle_on = 1'b1;
   int         items_sent = 0;
   int         quiet_after = 2147483647;

   base64_codec u_top (
      .clock          (clock),
      .reset          (reset),
      .req_data_in    (req_data_in),
      .req_last_in    (req_last_in),
      .req_push       (req_push),
      .req_full       (req_full),
      .rsp_data_out   (rsp_data_out),
      .rsp_last_out   (rsp_last_out),
      .rsp_error_flag (rsp_error_flag),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result side: pop with random stall bursts
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_pop <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_pop <= 1'b0;
            stall_left = $urandom_range(0, 4);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_symbol(rsp_data_out, rsp_last_out, rsp_error_flag);
   end

   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_wr_en)
            stuck = 0;
         else
            stuck++;
      end
      $display("watchdog expired with %0d results outstanding", sb.pending.size());
      $display("base64_codec verification failed");
      $finish;
   end

   task automatic send_item(input logic [7:0] d, input logic l);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_push <= 1'b1;
      req_data_in <= d;
      req_last_in <= l;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_item(d, l);
      items_sent++;
      // closing stretch runs at full rate
      if (items_sent >= quiet_after) idle_on = 1'b0;
   endtask

   // hold off until every result is out and a partial group has settled
   task automatic drain_and_wait();
      @(negedge clock);
      req_push <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic configure(input logic [7:0] mode_val, input logic [7:0] c62,
                            input logic [7:0] c63);
      drain_and_wait();
      csr_write(CSR_DIRECTION_MODE, mode_val);
      csr_write(CSR_ALPHABET_62, c62);
      csr_write(CSR_ALPHABET_63, c63);
   endtask

   function automatic logic [7:0] pick_alpha(input logic [7:0] dflt);
      case ($urandom_range(0, 7))
         0, 1, 2: return dflt;
         3: return 8'h00;
         4: return 8'hFF;
         5: return PAD_CHAR;
         6: return sb.to_char(6'($urandom_range(0, 61)));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_encode_stream();
      int n;
      n = $urandom_range(1, 7);
      for (int i = 0; i < n; i++) send_item(8'($urandom_range(0, 255)), i == n - 1);
   endtask

   // mostly well-formed groups; the rest truncated, misaligned, pure noise or sprinkled with padding
   task automatic send_decode_stream();
      logic [7:0] text[$];
      int         groups;
      int         pads;
      int         n;
      groups = $urandom_range(1, 2);
      for (int i = 0; i < 4 * groups; i++)
         text.push_back(sb.to_char(6'($urandom_range(0, 63))));
      pads = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2);
      for (int i = 0; i < pads; i++) text[text.size() - 1 - i] = PAD_CHAR;
      case ($urandom_range(0, 9))
         6: begin
            n = $urandom_range(1, 3);
            repeat (n) text.delete(text.size() - 1);
         end
         7: begin
            repeat ($urandom_range(1, 3))
               text.insert($urandom_range(0, text.size()), 8'($urandom_range(0, 255)));
         end
         8: begin
            text.delete();
            n = $urandom_range(1, 9);
            repeat (n)
               text.push_back(($urandom_range(0, 3) == 0) ? PAD_CHAR
                                                          : 8'($urandom_range(0, 255)));
         end
         9: begin
            for (int i = 0; i < text.size(); i++)
               if ($urandom_range(0, 2) == 0) text[i] = PAD_CHAR;
         end
         default: ;
      endcase
      for (int i = 0; i < text.size(); i++) send_item(text[i], i == text.size() - 1);
   endtask

   initial begin : main
      int         random_start;
      int         phase;
      logic       mode;
      logic [7:0] c62;
      logic [7:0] c63;

      sb = new();
      reset = 1'b1;
      req_push = 1'b0;
      req_data_in = 8'h00;
      req_last_in = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_DIRECTION_MODE;
      csr_wdata = 8'h00;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // encode with reset alphabet: full group then one-byte flush
      send_item("M", 1'b0);
      send_item("a", 1'b0);
      send_item("n", 1'b0);
      send_item(8'h00, 1'b1);
      // two-byte flush hitting both register characters
      send_item(8'hFB, 1'b0);
      send_item(8'hFF, 1'b1);
      // rewriting the mode drops a partial group
      send_item(8'h12, 1'b0);
      drain_and_wait();
      csr_write(CSR_DIRECTION_MODE, {7'd0, MODE_ENCODE});
      send_item("M", 1'b1);

      // decode; stray upper bits on the mode write, unused index ignored
      drain_and_wait();
      csr_write(CSR_DIRECTION_MODE, 8'h80 | {7'd0, MODE_DECODE});
      csr_write(CSR_UNUSED, 8'h5A);
      // unknown characters count as zero
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(PAD_CHAR, 1'b0);
      send_item(PAD_CHAR, 1'b0);
      // all-padding group mid-stream yields nothing, at the end an error
      repeat (4) send_item(PAD_CHAR, 1'b0);
      repeat (3) send_item(PAD_CHAR, 1'b0);
      send_item(PAD_CHAR, 1'b1);
      // short stream
      send_item("T", 1'b0);
      send_item("W", 1'b1);
      // letter in both registers: sextet 63 wins
      configure({7'd0, MODE_DECODE}, "B", "B");
      send_item("B", 1'b0);
      send_item("B", 1'b0);
      send_item(PAD_CHAR, 1'b0);
      send_item(PAD_CHAR, 1'b1);
      // pad in a register still pads
      configure({7'd0, MODE_DECODE}, PAD_CHAR, "A");
      send_item("A", 1'b0);
      send_item("A", 1'b0);
      send_item(PAD_CHAR, 1'b0);
      send_item(PAD_CHAR, 1'b1);

      random_start = items_sent;
      quiet_after = random_start + RANDOM_ITEMS * 4 / 5;
      phase = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if (phase < 2) begin
            mode = phase[0];
            c62 = phase[0] ? 8'hFF : 8'h00;
            c63 = ~c62;
         end else begin
            mode = $urandom_range(0, 1);
            c62 = pick_alpha(CHAR62_RESET);
            c63 = pick_alpha(CHAR63_RESET);
         end
         configure({7'($urandom_range(0, 127)), mode}, c62, c63);
         repeat ($urandom_range(2, 4)) begin
            if (mode == MODE_ENCODE) send_encode_stream();
            else send_decode_stream();
         end
         phase++;
      end

      drain_and_wait();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("base64_codec verification clean");
      end else begin
         $display("base64_codec verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/bcdc_pkg.sv
hdl/bcdc_front.sv
hdl/bcdc_queue.sv
hdl/bcdc_back.sv
hdl/base64_codec.sv
sim/base64_codec_tb.sv
